@@ hdl/tccw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // column values hold up to 255, row values up to 127
    localparam int CW = 8;
    localparam int RW = 7;

    // action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [2:0] REG_WIN_TOP    = 3'd1;
    localparam logic [2:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [2:0] REG_WIN_BOTTOM = 3'd3;
    localparam logic [2:0] REG_TEXT_ATTR  = 3'd4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [2:0]  BELL_LAST  = 3'd5;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       advance;
        logic [6:0] target_col;
        logic [4:0] target_row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        K_PUT, K_BELL, K_SET, K_CLEAR, K_READ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic       adv;
        logic [6:0] tcol;
        logic [4:0] trow;
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PUT, S_AFTER, S_SCR_RD, S_SCR_WR, S_SCR_BLANK,
        S_CLEAR, S_RD_WAIT, S_DONE
    } t_state;

    // text printed for a bell
    function automatic logic [7:0] bell_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h62;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/tccw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/tccw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Accepts input items, classifies the action and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module tccw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hold,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tccw_pkg::t_in_item i_in_item,
    output logic               o_cmd_valid,
    output tccw_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);
    import tccw_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;

    // classify the action
    always_comb begin
        cls.code = i_in_item.char_code;
        cls.adv  = i_in_item.advance;
        cls.tcol = i_in_item.target_col;
        cls.trow = i_in_item.target_row;
        case (i_in_item.action)
            ACT_PUT:   cls.kind = (i_in_item.char_code == CH_BELL) ? K_BELL : K_PUT;
            ACT_SET:   cls.kind = K_SET;
            ACT_CLEAR: cls.kind = K_CLEAR;
            default:   cls.kind = K_READ;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2) || i_hold;
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule

@@ hdl/tccw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Carries out commands on the screen store: cell writes, scroll and clear
// sweeps, cell reads, cursor and window registers.
// ----------------------------------------------------------------------------
module tccw_back #(
    parameter int COLUMNS   = 80,
    parameter int LINES     = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_hold,
    input  logic                i_cmd_valid,
    input  tccw_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tccw_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import tccw_pkg::*;

    localparam int CELLS = COLUMNS * LINES;
    localparam int AW    = $clog2(CELLS);
    localparam int KMAX  = COLUMNS / TAB_WIDTH + 1;
    localparam int XW    = CW + 1;

    t_state r_state, n_state;
    logic [AW-1:0] r_init, n_init;
    logic [6:0] r_left, r_right;
    logic [4:0] r_top, r_bottom;
    logic [7:0] r_attr;
    logic r_home, n_home;
    logic [CW-1:0] r_cx, n_cx, r_ccol, n_ccol;
    logic [RW-1:0] r_cy, n_cy, r_crow, n_crow;
    logic [7:0] r_ch, n_ch;
    logic r_adv, n_adv, r_adv_item, n_adv_item, r_bell, n_bell;
    logic [2:0] r_bidx, n_bidx;
    logic r_sc, n_sc, r_rd_ok, n_rd_ok;
    logic [15:0] r_cell, n_cell;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic [CW-1:0] lo_x, hi_x, cxs;
    logic [RW-1:0] lo_y, hi_y, cys;
    logic start;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;
    logic cfg_win;

    // put-step results
    logic [CW-1:0] pu_cx, bs_x, tab_x;
    logic [RW-1:0] pu_cy;
    logic pu_sc, pu_scroll, pu_we, nl;
    logic [CW-1:0] pu_wcol;
    logic [XW-1:0] nx9;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
                                                input logic [RW-1:0] row);
        return AW'(int'(row) * COLUMNS + int'(col));
    endfunction

    // clamped window
    always_comb begin
        lo_x = ({1'b0, r_left} > CW'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : {1'b0, r_left};
        lo_y = ({2'b0, r_top} > RW'(LINES - 1)) ? RW'(LINES - 1) : {2'b0, r_top};
        hi_x = ({1'b0, r_right} > CW'(COLUMNS)) ? CW'(COLUMNS) : {1'b0, r_right};
        if (hi_x <= lo_x) hi_x = lo_x + 1'b1;
        hi_y = ({2'b0, r_bottom} > RW'(LINES)) ? RW'(LINES) : {2'b0, r_bottom};
        if (hi_y <= lo_y) hi_y = lo_y + 1'b1;
        cxs = (r_cx < lo_x || r_cx >= hi_x) ? lo_x : r_cx;
        cys = (r_cy < lo_y || r_cy >= hi_y) ? lo_y : r_cy;
    end

    assign start       = (r_state == S_IDLE) && !r_home && i_cmd_valid && !r_out_valid;
    assign o_cmd_pop   = start;
    assign o_hold      = (r_state == S_INIT);
    assign o_cfg_ready = 1'b1;
    assign cfg_win     = i_cfg_valid && (i_cfg_index == REG_WIN_LEFT ||
                         i_cfg_index == REG_WIN_TOP || i_cfg_index == REG_WIN_RIGHT ||
                         i_cfg_index == REG_WIN_BOTTOM);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // next tab stop
    always_comb begin
        nx9 = XW'(TAB_WIDTH);
        for (int k = 1; k <= KMAX; k++) begin
            if ({1'b0, r_cx} >= XW'((k - 1) * TAB_WIDTH) && {1'b0, r_cx} < XW'(k * TAB_WIDTH))
                nx9 = XW'(k * TAB_WIDTH);
        end
    end

    // one character step at the cursor
    always_comb begin
        pu_cx     = r_cx;
        pu_cy     = r_cy;
        pu_sc     = 1'b0;
        pu_scroll = 1'b0;
        pu_we     = (r_ch >= CH_SPACE && r_ch <= CH_TILDE);
        pu_wcol   = r_cx;
        nl        = 1'b0;
        bs_x      = (r_cx > lo_x) ? r_cx - 1'b1 : lo_x;
        tab_x     = lo_x;
        case (r_ch)
            CH_NUL: ;
            CH_LF: nl = r_adv;
            CH_BS: begin
                pu_we   = 1'b1;
                pu_wcol = bs_x;
                pu_cx   = bs_x;
            end
            CH_TAB: begin
                logic [XW-1:0] t;
                t = nx9;
                if (r_adv && t >= {1'b0, hi_x}) begin
                    nl = 1'b1;
                    t  = t - {1'b0, hi_x - lo_x};
                end
                if (t < {1'b0, lo_x}) t = {1'b0, lo_x};
                if (t > {1'b0, hi_x - 1'b1}) t = {1'b0, hi_x - 1'b1};
                tab_x = t[CW-1:0];
            end
            default: begin
                if (r_cx < hi_x - 1'b1) pu_cx = r_cx + 1'b1;
                else nl = r_adv;
            end
        endcase
        if (nl) begin
            pu_cx = lo_x;
            if (r_cy + 1'b1 >= hi_y) begin
                pu_sc     = 1'b1;
                pu_cy     = hi_y - 1'b1;
                pu_scroll = (hi_y - lo_y >= RW'(2));
            end else begin
                pu_cy = r_cy + 1'b1;
            end
        end
        if (r_ch == CH_TAB) pu_cx = tab_x;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: if (r_init == AW'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.kind)
                        K_PUT, K_BELL: n_state = S_PUT;
                        K_CLEAR:       n_state = S_CLEAR;
                        K_READ:        n_state = S_RD_WAIT;
                        default:       n_state = S_DONE;
                    endcase
                end
            end
            S_PUT:    n_state = pu_scroll ? S_SCR_RD : S_AFTER;
            S_AFTER:  n_state = r_bell ? S_PUT : S_DONE;
            S_SCR_RD: n_state = S_SCR_WR;
            S_SCR_WR: begin
                if (r_ccol == hi_x - 1'b1 && r_crow == hi_y - 1'b1) n_state = S_SCR_BLANK;
                else n_state = S_SCR_RD;
            end
            S_SCR_BLANK: if (r_ccol == hi_x - 1'b1) n_state = S_AFTER;
            S_CLEAR: begin
                if (r_ccol == hi_x - 1'b1 && r_crow == hi_y - 1'b1) n_state = S_DONE;
            end
            S_RD_WAIT: n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_init      = r_init;
        n_home      = r_home;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_ccol      = r_ccol;
        n_crow      = r_crow;
        n_ch        = r_ch;
        n_adv       = r_adv;
        n_adv_item  = r_adv_item;
        n_bell      = r_bell;
        n_bidx      = r_bidx;
        n_sc        = r_sc;
        n_rd_ok     = r_rd_ok;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = cell_addr(r_cx, r_cy);
        wdata       = {r_attr, CH_SPACE};
        raddr       = cell_addr(r_ccol, r_crow);
        case (r_state)
            S_INIT: begin
                we     = 1'b1;
                waddr  = r_init;
                wdata  = BLANK_CELL;
                n_init = r_init + 1'b1;
            end
            S_IDLE: begin
                if (r_home) begin
                    n_cx   = lo_x;
                    n_cy   = lo_y;
                    n_home = 1'b0;
                end else if (start) begin
                    n_cx    = cxs;
                    n_cy    = cys;
                    n_sc    = 1'b0;
                    n_cell  = 16'd0;
                    n_ch    = i_cmd.code;
                    n_adv   = i_cmd.adv;
                    n_bell  = 1'b0;
                    n_bidx  = 3'd0;
                    n_ccol  = lo_x;
                    n_crow  = lo_y;
                    n_rd_ok = ({1'b0, i_cmd.tcol} < CW'(COLUMNS)) &&
                              ({2'b0, i_cmd.trow} < RW'(LINES));
                    raddr   = cell_addr({1'b0, i_cmd.tcol}, {2'b0, i_cmd.trow});
                    case (i_cmd.kind)
                        K_BELL: begin
                            n_ch       = bell_char(3'd0);
                            n_adv      = 1'b1;
                            n_adv_item = i_cmd.adv;
                            n_bell     = 1'b1;
                        end
                        K_SET: begin
                            n_cx = (lo_x + {1'b0, i_cmd.tcol} > hi_x - 1'b1) ?
                                   hi_x - 1'b1 : lo_x + {1'b0, i_cmd.tcol};
                            n_cy = (lo_y + {2'b0, i_cmd.trow} > hi_y - 1'b1) ?
                                   hi_y - 1'b1 : lo_y + {2'b0, i_cmd.trow};
                        end
                        default: ;
                    endcase
                end
            end
            S_PUT: begin
                we     = pu_we;
                waddr  = cell_addr(pu_wcol, r_cy);
                wdata  = {r_attr, (r_ch == CH_BS) ? CH_SPACE : r_ch};
                n_cx   = pu_cx;
                n_cy   = pu_cy;
                n_sc   = r_sc | pu_sc;
                n_ccol = lo_x;
                n_crow = lo_y + 1'b1;
            end
            S_AFTER: begin
                if (r_bell) begin
                    if (r_bidx == BELL_LAST) begin
                        n_bell = 1'b0;
                        n_ch   = CH_BELL;
                        n_adv  = r_adv_item;
                    end else begin
                        n_bidx = r_bidx + 1'b1;
                        n_ch   = bell_char(r_bidx + 1'b1);
                    end
                end
            end
            S_SCR_WR: begin
                we    = 1'b1;
                waddr = cell_addr(r_ccol, r_crow - 1'b1);
                wdata = rdata;
                if (r_ccol == hi_x - 1'b1) begin
                    n_ccol = lo_x;
                    if (r_crow != hi_y - 1'b1) n_crow = r_crow + 1'b1;
                end else begin
                    n_ccol = r_ccol + 1'b1;
                end
            end
            S_SCR_BLANK: begin
                we     = 1'b1;
                waddr  = cell_addr(r_ccol, hi_y - 1'b1);
                n_ccol = r_ccol + 1'b1;
            end
            S_CLEAR: begin
                we    = 1'b1;
                waddr = cell_addr(r_ccol, r_crow);
                n_cx  = lo_x;
                n_cy  = lo_y;
                if (r_ccol == hi_x - 1'b1) begin
                    n_ccol = lo_x;
                    n_crow = r_crow + 1'b1;
                end else begin
                    n_ccol = r_ccol + 1'b1;
                end
            end
            S_RD_WAIT: n_cell = r_rd_ok ? rdata : 16'd0;
            S_DONE: begin
                n_out_valid      = 1'b1;
                n_out.cell_value = r_cell;
                n_out.cursor_col = 7'(r_cx - lo_x);
                n_out.cursor_row = 5'(r_cy - lo_y);
                n_out.scrolled   = r_sc;
            end
            default: ;
        endcase
        if (cfg_win) n_home = 1'b1;
    end

    // screen store
    tccw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_home      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_bell      <= 1'b0;
            r_left      <= 7'd0;
            r_top       <= 5'd0;
            r_right     <= 7'd80;
            r_bottom    <= 5'd25;
            r_attr      <= 8'd7;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_home      <= n_home;
            r_out_valid <= n_out_valid;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_bell      <= n_bell;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WIN_LEFT:   r_left   <= i_cfg_data[6:0];
                    REG_WIN_TOP:    r_top    <= i_cfg_data[4:0];
                    REG_WIN_RIGHT:  r_right  <= i_cfg_data[6:0];
                    REG_WIN_BOTTOM: r_bottom <= i_cfg_data[4:0];
                    REG_TEXT_ATTR:  r_attr   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ccol     <= n_ccol;
        r_crow     <= n_crow;
        r_ch       <= n_ch;
        r_adv      <= n_adv;
        r_adv_item <= n_adv_item;
        r_bidx     <= n_bidx;
        r_sc       <= n_sc;
        r_rd_ok    <= n_rd_ok;
        r_cell     <= n_cell;
        r_out      <= n_out;
    end
endmodule

@@ hdl/text_console_char_writer_unit.sv @@
`timescale 1ns / 1ps
// The back end sequencer takes the next command only after the previous result
// transfer; a scroll moves each window cell below the top line up one line and
// blanks the bottom line, and a clear writes every cell of the window.
// Reset: synchronous; a clearing pass blanks every cell of the store, during
// which no item is accepted (configuration writes are taken).
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text-mode console writer: command queue front end and store back end.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
    parameter int COLUMNS   = 80,
    parameter int LINES     = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tccw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tccw_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import tccw_pkg::*;

    logic cmd_valid, cmd_pop, hold;
    t_cmd cmd;

    // front end: classify and queue
    tccw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (hold),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back end: execute on the screen store
    tccw_back #(.COLUMNS(COLUMNS), .LINES(LINES), .TAB_WIDTH(TAB_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_hold      (hold),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule

@@ bench/text_console_char_writer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the item, result and register channels of the console writer,
// keeps its own screen, cursor and window, predicts each result and compares.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  tccw_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tccw_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import tccw_pkg::*;

    localparam int NCOL = 80;
    localparam int NROW = 25;
    localparam int TABW = 8;

    logic [15:0] screen [NCOL*NROW];
    int cur_x, cur_y;
    int reg_left, reg_top, reg_right, reg_bottom;
    logic [7:0] attr;
    int wx0, wy0, wx1, wy1;
    t_out_item expected_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    function automatic void limit_window();
        wx0 = reg_left > NCOL - 1 ? NCOL - 1 : reg_left;
        wy0 = reg_top > NROW - 1 ? NROW - 1 : reg_top;
        wx1 = reg_right > NCOL ? NCOL : reg_right;
        if (wx1 <= wx0) wx1 = wx0 + 1;
        wy1 = reg_bottom > NROW ? NROW : reg_bottom;
        if (wy1 <= wy0) wy1 = wy0 + 1;
    endfunction

    function automatic void put_cell(input int col, input int row, input logic [7:0] ch);
        if (col < NCOL && row < NROW) screen[row*NCOL + col] = {attr, ch};
    endfunction

    function automatic bit line_feed();
        cur_x = wx0;
        if (cur_y + 1 >= wy1) begin
            if (wy1 - wy0 >= 2) begin
                for (int r = wy0 + 1; r < wy1; r++)
                    for (int c = wx0; c < wx1; c++)
                        screen[(r-1)*NCOL + c] = screen[r*NCOL + c];
                for (int c = wx0; c < wx1; c++) put_cell(c, wy1 - 1, CH_SPACE);
            end
            cur_y = wy1 - 1;
            return 1;
        end
        cur_y++;
        return 0;
    endfunction

    function automatic bit move_cursor(input logic [7:0] c, input bit adv);
        int nx;
        bit sc;
        sc = 0;
        case (c)
            CH_NUL: ;
            CH_LF: if (adv) sc = line_feed();
            CH_BS: begin
                nx = cur_x > wx0 ? cur_x - 1 : wx0;
                put_cell(nx, cur_y, CH_SPACE);
                cur_x = nx;
            end
            CH_TAB: begin
                nx = (cur_x / TABW + 1) * TABW;
                if (adv && nx >= wx1) begin
                    sc = line_feed();
                    nx -= wx1 - wx0;
                end
                if (nx < wx0) nx = wx0;
                if (nx > wx1 - 1) nx = wx1 - 1;
                cur_x = nx;
            end
            default: begin
                if (cur_x < wx1 - 1) cur_x++;
                else if (adv) sc = line_feed();
            end
        endcase
        return sc;
    endfunction

    function automatic logic [7:0] bell_text(input int i);
        case (i)
            0: return "(";
            1: return "b";
            2: return "e";
            3: return "l";
            4: return "l";
            default: return ")";
        endcase
    endfunction

    function automatic t_out_item predict_console(input t_in_item it);
        t_out_item r;
        logic [7:0] b;
        bit sc;
        sc = 0;
        r = '0;
        limit_window();
        if (cur_x < wx0 || cur_x >= wx1) cur_x = wx0;
        if (cur_y < wy0 || cur_y >= wy1) cur_y = wy0;
        case (it.action)
            ACT_PUT: begin
                if (it.char_code >= CH_SPACE && it.char_code <= CH_TILDE)
                    put_cell(cur_x, cur_y, it.char_code);
                else if (it.char_code == CH_BELL)
                    for (int i = 0; i < 6; i++) begin
                        b = bell_text(i);
                        put_cell(cur_x, cur_y, b);
                        if (move_cursor(b, 1)) sc = 1;
                    end
                if (move_cursor(it.char_code, it.advance)) sc = 1;
            end
            ACT_SET: begin
                cur_x = wx0 + it.target_col > wx1 - 1 ? wx1 - 1 : wx0 + it.target_col;
                cur_y = wy0 + it.target_row > wy1 - 1 ? wy1 - 1 : wy0 + it.target_row;
            end
            ACT_CLEAR: begin
                for (int rr = wy0; rr < wy1; rr++)
                    for (int c = wx0; c < wx1; c++) put_cell(c, rr, CH_SPACE);
                cur_x = wx0;
                cur_y = wy0;
            end
            default:
                if (it.target_col < NCOL && it.target_row < NROW)
                    r.cell_value = screen[it.target_row*NCOL + it.target_col];
        endcase
        r.cursor_col = 7'(cur_x - wx0);
        r.cursor_row = 5'(cur_y - wy0);
        r.scrolled = sc;
        return r;
    endfunction

    // predict on every transfer, compare every result
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (screen[i]) screen[i] = BLANK_CELL;
            cur_x = 0; cur_y = 0;
            reg_left = 0; reg_top = 0; reg_right = 80; reg_bottom = 25;
            attr = 8'd7;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIN_LEFT:   reg_left = i_cfg_data[6:0];
                    REG_WIN_TOP:    reg_top = i_cfg_data[4:0];
                    REG_WIN_RIGHT:  reg_right = i_cfg_data[6:0];
                    REG_WIN_BOTTOM: reg_bottom = i_cfg_data[4:0];
                    REG_TEXT_ATTR:  attr = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= REG_WIN_BOTTOM) begin
                    limit_window();
                    cur_x = wx0;
                    cur_y = wy0;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_console(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(i_out_item), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.cell_value !== want.cell_value)
                        report_mismatch("cell_value", int'(i_out_item.cell_value),
                                        int'(want.cell_value));
                    if (i_out_item.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", int'(i_out_item.cursor_col),
                                        int'(want.cursor_col));
                    if (i_out_item.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", int'(i_out_item.cursor_row),
                                        int'(want.cursor_row));
                    if (i_out_item.scrolled !== want.scrolled)
                        report_mismatch("scrolled", int'(i_out_item.scrolled),
                                        int'(want.scrolled));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/text_console_char_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_tb
// Drives directed and random console actions through several windows and
// attributes with random bursts and output stalls; the checker compares.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_tb;
    import tccw_pkg::*;

    logic i_clk, i_rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    t_in_item in_item;
    t_out_item out_item;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int errors, pending;
    bit hold_off_req;
    int stall_mode;

    text_console_char_writer_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    text_console_char_writer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off_req = 0;
                out_stall <= 1'b0;
            end else if (stall_mode == 0) out_stall <= 1'b0;
            else out_stall <= ($urandom_range(99) < stall_mode);
        end
    end

    initial begin
        #400_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // one item transfer
    task automatic send_action(input logic [1:0] act, input logic [7:0] code,
                               input logic adv, input int col, input int row);
        in_valid <= 1'b1;
        in_item <= '{action: act, char_code: code, advance: adv,
                     target_col: 7'(col), target_row: 5'(row)};
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_all();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < 200000);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_code();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 8'($urandom_range(8'h20, 8'h7E));
        if (p < 65) return CH_LF;
        if (p < 71) return CH_TAB;
        if (p < 77) return CH_BS;
        if (p < 79) return CH_BELL;
        if (p < 81) return CH_NUL;
        return 8'($urandom);
    endfunction

    // random bursts of mostly text
    task automatic random_phase(input int n);
        int burst, p;
        logic [1:0] act;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++, n--) begin
                p = $urandom_range(999);
                if (p < 880) act = ACT_PUT;
                else if (p < 930) act = ACT_SET;
                else if (p < 935) act = ACT_CLEAR;
                else act = ACT_READ;
                send_action(act, random_code(), $urandom_range(9) != 0,
                            $urandom_range(127), $urandom_range(31));
            end
            if ($urandom_range(2) != 0) idle_cycles($urandom_range(1, 6));
        end
        drain_all();
    endtask

    task automatic set_window(input int l, input int t, input int r, input int b,
                              input logic [7:0] a);
        write_reg(REG_WIN_LEFT, 8'(l));
        write_reg(REG_WIN_TOP, 8'(t));
        write_reg(REG_WIN_RIGHT, 8'(r));
        write_reg(REG_WIN_BOTTOM, 8'(b));
        write_reg(REG_TEXT_ATTR, a);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off_req = 0;
        stall_mode = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and every special character
        send_action(ACT_READ, 8'h00, 1'b0, 0, 0);
        send_action(ACT_READ, 8'hFF, 1'b1, 127, 31);
        send_action(ACT_PUT, CH_TILDE, 1'b1, 0, 0);
        send_action(ACT_PUT, CH_SPACE, 1'b0, 0, 0);
        send_action(ACT_PUT, CH_BELL, 1'b0, 0, 0);
        send_action(ACT_PUT, CH_NUL, 1'b1, 0, 0);
        send_action(ACT_PUT, CH_BS, 1'b1, 0, 0);
        send_action(ACT_PUT, CH_TAB, 1'b1, 0, 0);
        send_action(ACT_PUT, 8'hFF, 1'b1, 0, 0);
        send_action(ACT_SET, 8'h00, 1'b0, 79, 24);
        send_action(ACT_PUT, 8'h41, 1'b0, 0, 0);
        send_action(ACT_PUT, CH_LF, 1'b0, 0, 0);
        send_action(ACT_PUT, CH_TAB, 1'b0, 0, 0);
        send_action(ACT_PUT, CH_TAB, 1'b1, 0, 0);
        send_action(ACT_SET, 8'h00, 1'b0, 127, 31);
        send_action(ACT_PUT, 8'h42, 1'b1, 0, 0);
        send_action(ACT_PUT, CH_LF, 1'b1, 0, 0);
        send_action(ACT_READ, 8'h00, 1'b0, 79, 24);
        send_action(ACT_READ, 8'h00, 1'b0, 0, 23);
        send_action(ACT_CLEAR, 8'h00, 1'b0, 0, 0);
        send_action(ACT_READ, 8'h00, 1'b0, 0, 0);
        drain_all();

        // random phases across windows, stall styles and one long hold-off
        stall_mode = 30;
        random_phase(250);
        set_window(10, 5, 30, 9, 8'hFF);
        stall_mode = 0;
        random_phase(200);
        set_window(79, 24, 0, 0, 8'h00);
        stall_mode = 50;
        random_phase(100);
        set_window(127, 31, 127, 31, 8'hA5);
        random_phase(50);
        set_window(3, 0, 12, 25, 8'h5A);
        hold_off_req = 1;
        stall_mode = 20;
        random_phase(200);
        set_window(0, 20, 80, 22, 8'h1E);
        random_phase(150);
        set_window(0, 0, 80, 25, 8'h07);
        stall_mode = 10;
        random_phase(150);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
